// ----- design/cantxq_pkg.sv -----
`timescale 1ns / 1ps

package cantxq_pkg;

  typedef enum logic [1:0] {
    MODE_SETUP = 2'd0,
    MODE_SEND  = 2'd1,
    MODE_FREED = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_INDEX    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  localparam logic [3:0] MAX_LEN = 4'd8;

  // stored buffer header
  typedef struct packed {
    logic        sync;
    logic [3:0]  length;
    logic        rtr;
    logic [10:0] ident;
  } meta_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic err_idx;
    logic setup;
    logic send;
    logic free_start;
    logic free_step;
    logic clr_start;
    logic clr_step;
    logic clr_done;
    logic rd_scan;
    logic load_none;
    logic load_frame;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  idx_bad;
    logic  mb_zero;
    logic  scan_end;
    logic  free_stop;
    logic  free_none;
    logic  frm_last;
    logic  out_free;
  } sts_t;

  // keeps the first len bytes, all bytes from eight upward
  function automatic logic [63:0] len_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- design/cantxq_ram.sv -----
`timescale 1ns / 1ps

module cantxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/cantxq_ctrl.sv -----
`timescale 1ns / 1ps

module cantxq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cantxq_pkg::sts_t   sts,
  output cantxq_pkg::cmd_t   cmd
);

  import cantxq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FREE_SCAN,
    ST_CLR_SCAN,
    ST_CLR_DONE,
    ST_EMIT_NONE,
    ST_FRM_RD,
    ST_FRM_OUT
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.mode)
          MODE_SETUP: begin
            if (sts.idx_bad) begin
              cmd.err_idx = 1'b1;
            end else begin
              cmd.setup = 1'b1;
            end
            state_next = ST_EMIT_NONE;
          end
          MODE_SEND: begin
            if (sts.idx_bad) begin
              cmd.err_idx = 1'b1;
              state_next  = ST_EMIT_NONE;
            end else begin
              cmd.send   = 1'b1;
              state_next = sts.mb_zero ? ST_EMIT_NONE : ST_FRM_RD;
            end
          end
          MODE_FREED: begin
            cmd.free_start = 1'b1;
            state_next     = sts.mb_zero ? ST_EMIT_NONE : ST_FREE_SCAN;
          end
          MODE_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = ST_CLR_SCAN;
          end
        endcase
      end
      ST_FREE_SCAN: begin
        cmd.free_step = 1'b1;
        if (sts.free_stop) begin
          state_next = sts.free_none ? ST_EMIT_NONE : ST_FRM_RD;
        end
      end
      ST_CLR_SCAN: begin
        cmd.clr_step = 1'b1;
        cmd.rd_scan  = 1'b1;
        if (sts.scan_end) begin
          state_next = ST_CLR_DONE;
        end
      end
      ST_CLR_DONE: begin
        cmd.clr_done = 1'b1;
        state_next   = ST_EMIT_NONE;
      end
      ST_EMIT_NONE: begin
        if (sts.out_free) begin
          cmd.load_none = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_FRM_RD: begin
        state_next = ST_FRM_OUT;
      end
      ST_FRM_OUT: begin
        if (sts.out_free) begin
          cmd.load_frame = 1'b1;
          state_next     = sts.frm_last ? ST_IDLE : ST_FRM_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/cantxq_dp.sv -----
`timescale 1ns / 1ps

module cantxq_dp #(
  parameter int TX_BUFFERS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  cantxq_pkg::cmd_t  cmd,
  output cantxq_pkg::sts_t  sts,
  input  logic [1:0]        mode,
  input  logic [5:0]        buf_index,
  input  logic [10:0]       ident,
  input  logic              rtr,
  input  logic [3:0]        length,
  input  logic              sync,
  input  logic [63:0]       payload,
  input  logic [1:0]        mailboxes_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              frame_valid,
  output logic [5:0]        frame_buffer,
  output logic [10:0]       frame_ident,
  output logic              frame_rtr,
  output logic [3:0]        frame_length,
  output logic [63:0]       frame_data,
  output logic [1:0]        fault_code,
  output logic              overflow_flag,
  output logic              pdo_late_flag,
  output logic [6:0]        pending_count,
  output logic              last
);

  import cantxq_pkg::*;

  localparam int AW = (TX_BUFFERS > 1) ? $clog2(TX_BUFFERS) : 1;

  // latched request
  mode_t       mode_r;
  logic [5:0]  idx_r;
  logic [10:0] ident_r;
  logic        rtr_r;
  logic [3:0]  len_r;
  logic        sync_r;
  logic [63:0] payload_r;
  logic [1:0]  mb_r;

  logic [TX_BUFFERS-1:0] buf_full;
  logic [6:0]  pending;
  logic        inhibit;
  logic        first_msg;
  logic        ovf;
  logic        late;
  logic        dropped;
  err_t        err;

  logic [AW-1:0] scan_idx;
  logic [AW-1:0] chk_idx;
  logic          chk_v;
  logic [1:0]    budget;
  logic [AW-1:0] frm_list [3];
  logic [1:0]    frm_cnt;
  logic [1:0]    frm_ptr;

  logic [AW-1:0] idx_a;
  logic [AW-1:0] rd_addr;
  logic          idx_bad;
  logic          scan_end;
  logic          full_hit;
  logic          clr_hit;
  logic          out_free;
  logic          frm_last;
  meta_t         meta_wr;
  meta_t         meta_rd;
  logic [63:0]   data_rd;

  assign idx_a    = idx_r[AW-1:0];
  assign idx_bad  = ({1'b0, idx_r} >= 7'(TX_BUFFERS));
  assign scan_end = (scan_idx == AW'(TX_BUFFERS - 1));
  assign full_hit = buf_full[scan_idx];
  assign clr_hit  = chk_v && buf_full[chk_idx] && meta_rd.sync;
  assign out_free = !out_valid || !out_stall;
  assign frm_last = (frm_ptr == (frm_cnt - 2'd1));
  assign rd_addr  = cmd.rd_scan ? scan_idx : frm_list[frm_ptr];

  always_comb begin
    sts.mode      = mode_r;
    sts.idx_bad   = idx_bad;
    sts.mb_zero   = (mb_r == 2'd0);
    sts.scan_end  = scan_end;
    sts.free_stop = scan_end || ((budget == 2'd1) && full_hit);
    sts.free_none = (frm_cnt == 2'd0) && !full_hit;
    sts.frm_last  = frm_last;
    sts.out_free  = out_free;
  end

  always_comb begin
    meta_wr.sync   = sync_r;
    meta_wr.length = (len_r > MAX_LEN) ? MAX_LEN : len_r;
    meta_wr.rtr    = rtr_r;
    meta_wr.ident  = ident_r;
  end

  cantxq_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (TX_BUFFERS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (cmd.setup),
    .waddr (idx_a),
    .wdata (meta_wr),
    .raddr (rd_addr),
    .rdata (meta_rd)
  );

  cantxq_ram #(
    .WIDTH (64),
    .DEPTH (TX_BUFFERS)
  ) u_data_ram (
    .clk   (clk),
    .we    (cmd.send),
    .waddr (idx_a),
    .wdata (payload_r),
    .raddr (rd_addr),
    .rdata (data_rd)
  );

  // request fields and frame list
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= mode_t'(mode);
      idx_r     <= buf_index;
      ident_r   <= ident;
      rtr_r     <= rtr;
      len_r     <= length;
      sync_r    <= sync;
      payload_r <= payload;
      mb_r      <= mailboxes_free;
    end
    if (cmd.send && (mb_r != 2'd0)) begin
      frm_list[0] <= idx_a;
    end
    if (cmd.free_step && full_hit) begin
      frm_list[frm_cnt] <= scan_idx;
    end
    if (cmd.clr_step) begin
      chk_idx <= scan_idx;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.load_none || cmd.load_frame) begin
      fault_code    <= err;
      overflow_flag <= ovf;
      pdo_late_flag <= late;
      pending_count <= pending;
    end
    if (cmd.load_none) begin
      frame_valid  <= 1'b0;
      frame_buffer <= '0;
      frame_ident  <= '0;
      frame_rtr    <= 1'b0;
      frame_length <= '0;
      frame_data   <= '0;
      last         <= 1'b1;
    end else if (cmd.load_frame) begin
      frame_valid  <= 1'b1;
      frame_buffer <= 6'(rd_addr);
      frame_ident  <= meta_rd.ident;
      frame_rtr    <= meta_rd.rtr;
      frame_length <= meta_rd.length;
      frame_data   <= data_rd & len_mask(meta_rd.length);
      last         <= frm_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full  <= '0;
      pending   <= '0;
      inhibit   <= 1'b0;
      first_msg <= 1'b1;
      ovf       <= 1'b0;
      late      <= 1'b0;
      dropped   <= 1'b0;
      err       <= ERR_NONE;
      scan_idx  <= '0;
      chk_v     <= 1'b0;
      budget    <= '0;
      frm_cnt   <= '0;
      frm_ptr   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.capture) begin
        err <= ERR_NONE;
      end
      if (cmd.err_idx) begin
        err <= ERR_INDEX;
      end
      if (cmd.setup && buf_full[idx_a]) begin
        buf_full[idx_a] <= 1'b0;
        if (pending != 7'd0) begin
          pending <= pending - 7'd1;
        end
      end
      if (cmd.send) begin
        if (buf_full[idx_a]) begin
          err <= ERR_OVERFLOW;
          if (!first_msg) begin
            ovf <= 1'b1;
          end
        end
        if (mb_r != 2'd0) begin
          frm_cnt <= 2'd1;
          frm_ptr <= 2'd0;
        end else if (!buf_full[idx_a]) begin
          buf_full[idx_a] <= 1'b1;
          pending         <= pending + 7'd1;
        end
      end
      if (cmd.free_start) begin
        first_msg <= 1'b0;
        inhibit   <= 1'b0;
        budget    <= mb_r;
        frm_cnt   <= 2'd0;
        frm_ptr   <= 2'd0;
        scan_idx  <= '0;
      end
      if (cmd.free_step) begin
        if (full_hit) begin
          buf_full[scan_idx] <= 1'b0;
          if (pending != 7'd0) begin
            pending <= pending - 7'd1;
          end
          budget  <= budget - 2'd1;
          frm_cnt <= frm_cnt + 2'd1;
        end
        if (!scan_end) begin
          scan_idx <= scan_idx + AW'(1);
        end
      end
      if (cmd.clr_start) begin
        dropped  <= inhibit;
        inhibit  <= 1'b0;
        scan_idx <= '0;
        chk_v    <= 1'b0;
      end
      // acts on the registered header read and its registered index chk_idx
      if ((cmd.clr_step || cmd.clr_done) && clr_hit) begin
        buf_full[chk_idx] <= 1'b0;
        if (pending != 7'd0) begin
          pending <= pending - 7'd1;
        end
        dropped <= 1'b1;
      end
      if (cmd.clr_step) begin
        chk_v <= 1'b1;
        if (!scan_end) begin
          scan_idx <= scan_idx + AW'(1);
        end
      end
      if (cmd.clr_done) begin
        chk_v <= 1'b0;
        if (dropped || clr_hit) begin
          late <= 1'b1;
        end
      end
      if (cmd.load_none) begin
        out_valid <= 1'b1;
      end
      if (cmd.load_frame) begin
        out_valid <= 1'b1;
        inhibit   <= meta_rd.sync;
        if (!frm_last) begin
          frm_ptr <= frm_ptr + 2'd1;
        end
      end
    end
  end

  a_pending_matches_flags: assert property (@(posedge clk) disable iff (rst)
    $countones(buf_full) == int'(pending))
    else $error("pending count differs from number of pending buffers");

  a_frame_ptr_in_list: assert property (@(posedge clk) disable iff (rst)
    (frm_cnt != 2'd0) |-> (frm_ptr < frm_cnt))
    else $error("frame pointer beyond collected frames");

  a_no_frame_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_valid) |-> (frame_data == 64'd0 && frame_ident == 11'd0
                                     && frame_length == 4'd0 && last))
    else $error("result without frame carries frame fields");

  a_late_after_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.clr_done && clr_hit) |=> late)
    else $error("dropped sync buffer did not raise late status");

endmodule

// ----- design/can_tx_buffer_queue.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake            fields
// request   in         in_valid / in_stall  mode buf_index ident rtr length sync
//                                           payload mailboxes_free
// result    out        out_valid / out_stall frame_* fault_code overflow_flag
//                                           pdo_late_flag pending_count last
//
// setup, error and send without a free mailbox give an empty result, send with a mailbox one frame
// mailboxes freed: a flag scan, then a stored read and a result per frame,
// or an empty result when no pending buffer is found
// sync clear: one stored header read per buffer on the one read port
// reset clears the pending flags at once; stored headers and data are undefined
// in_stall is high while a request is in progress; out_stall holds the result register

module can_tx_buffer_queue #(
  parameter int TX_BUFFERS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [5:0]  buf_index,
  input  logic [10:0] ident,
  input  logic        rtr,
  input  logic [3:0]  length,
  input  logic        sync,
  input  logic [63:0] payload,
  input  logic [1:0]  mailboxes_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_valid,
  output logic [5:0]  frame_buffer,
  output logic [10:0] frame_ident,
  output logic        frame_rtr,
  output logic [3:0]  frame_length,
  output logic [63:0] frame_data,
  output logic [1:0]  fault_code,
  output logic        overflow_flag,
  output logic        pdo_late_flag,
  output logic [6:0]  pending_count,
  output logic        last
);

  import cantxq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cantxq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cantxq_dp #(
    .TX_BUFFERS (TX_BUFFERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .mode           (mode),
    .buf_index      (buf_index),
    .ident          (ident),
    .rtr            (rtr),
    .length         (length),
    .sync           (sync),
    .payload        (payload),
    .mailboxes_free (mailboxes_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_valid    (frame_valid),
    .frame_buffer   (frame_buffer),
    .frame_ident    (frame_ident),
    .frame_rtr      (frame_rtr),
    .frame_length   (frame_length),
    .frame_data     (frame_data),
    .fault_code     (fault_code),
    .overflow_flag  (overflow_flag),
    .pdo_late_flag  (pdo_late_flag),
    .pending_count  (pending_count),
    .last           (last)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import cantxq_pkg::*;

  localparam int NBUF = 32;

  typedef struct packed {
    mode_t       op;
    logic [5:0]  idx;
    logic [10:0] ident;
    logic        rtr;
    logic [3:0]  len;
    logic        sync;
    logic [63:0] payload;
    logic [1:0]  mb;
  } txreq_t;

  typedef struct packed {
    logic        frame_valid;
    logic [5:0]  buffer;
    logic [10:0] ident;
    logic        rtr;
    logic [3:0]  len;
    logic [63:0] data;
    logic [1:0]  err;
    logic        ovf;
    logic        late;
    logic [6:0]  pend;
    logic        last;
  } txres_t;

  // mirrors the buffer table and checks each transmitted result in order
  class tx_frame_board;
    logic [10:0] id_q   [NBUF];
    logic        rtr_q  [NBUF];
    logic [3:0]  len_q  [NBUF];
    logic        sync_q [NBUF];
    logic        full_q [NBUF];
    logic [63:0] data_q [NBUF];
    int unsigned pend_total;
    bit          inhibit;
    bit          first_msg;
    bit          ovf_st;
    bit          late_st;
    txres_t      awaited_q[$];
    int          errors;
    int          results;
    int          frames;
    int          req_count[4];
    bit          ovf_seen;
    bit          late_seen;

    function new();
      foreach (full_q[i]) full_q[i] = 1'b0;
      pend_total = 0;
      inhibit    = 1'b0;
      first_msg  = 1'b1;
      ovf_st     = 1'b0;
      late_st    = 1'b0;
    endfunction

    function txres_t load_frame(int b);
      txres_t      r;
      logic [63:0] keep;
      int          k;
      r    = '0;
      keep = '0;
      for (k = 0; k < 8; k++) begin
        if (k < len_q[b]) keep[8*k +: 8] = 8'hFF;
      end
      r.frame_valid = 1'b1;
      r.buffer      = 6'(b);
      r.ident       = id_q[b];
      r.rtr         = rtr_q[b];
      r.len         = len_q[b];
      r.data        = data_q[b] & keep;
      return r;
    endfunction

    function void note_request(txreq_t q);
      txres_t      outs[3];
      int          n;
      int          k;
      int          left;
      logic [1:0]  err;
      bit          dropped;
      n       = 1;
      err     = ERR_NONE;
      dropped = 1'b0;
      foreach (outs[i]) outs[i] = '0;
      req_count[q.op]++;
      case (q.op)
        MODE_SETUP, MODE_SEND: begin
          if (q.idx >= NBUF) begin
            err = ERR_INDEX;
          end else if (q.op == MODE_SETUP) begin
            id_q[q.idx]   = q.ident;
            rtr_q[q.idx]  = q.rtr;
            len_q[q.idx]  = (q.len > MAX_LEN) ? MAX_LEN : q.len;
            sync_q[q.idx] = q.sync;
            if (full_q[q.idx] && pend_total > 0) pend_total--;
            full_q[q.idx] = 1'b0;
          end else begin
            data_q[q.idx] = q.payload;
            if (full_q[q.idx]) begin
              // overflow status stays low until the first freed event
              if (!first_msg) ovf_st = 1'b1;
              err = ERR_OVERFLOW;
            end
            if (q.mb != 0) begin
              outs[0] = load_frame(q.idx);
              inhibit = sync_q[q.idx];
            end else if (!full_q[q.idx]) begin
              full_q[q.idx] = 1'b1;
              pend_total++;
            end
          end
        end
        MODE_FREED: begin
          first_msg = 1'b0;
          inhibit   = 1'b0;
          left      = q.mb;
          n         = 0;
          for (k = 0; k < NBUF && left > 0; k++) begin
            if (full_q[k]) begin
              outs[n] = load_frame(k);
              n++;
              left--;
              full_q[k] = 1'b0;
              if (pend_total > 0) pend_total--;
              inhibit = sync_q[k];
            end
          end
          if (n == 0) n = 1;
        end
        default: begin
          dropped = inhibit;
          inhibit = 1'b0;
          for (k = 0; k < NBUF; k++) begin
            if (full_q[k] && sync_q[k]) begin
              full_q[k] = 1'b0;
              if (pend_total > 0) pend_total--;
              dropped = 1'b1;
            end
          end
          if (dropped) late_st = 1'b1;
        end
      endcase
      ovf_seen  |= ovf_st;
      late_seen |= late_st;
      for (k = 0; k < n; k++) begin
        outs[k].err  = err;
        outs[k].ovf  = ovf_st;
        outs[k].late = late_st;
        outs[k].pend = 7'(pend_total);
        outs[k].last = (k == n - 1);
        if (outs[k].frame_valid) frames++;
        awaited_q.push_back(outs[k]);
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch %0d at result %0d: %s got %0h want %0h",
                 errors, results, what, got, want);
    endtask

    task check_result(txres_t got);
      txres_t want;
      results++;
      if (awaited_q.size() == 0) begin
        report_mismatch("result with no request behind it", 0, 0);
        return;
      end
      want = awaited_q.pop_front();
      if (got.frame_valid !== want.frame_valid)
        report_mismatch("frame_valid", got.frame_valid, want.frame_valid);
      if (got.buffer !== want.buffer)
        report_mismatch("frame_buffer", got.buffer, want.buffer);
      if (got.ident !== want.ident)
        report_mismatch("frame_ident", got.ident, want.ident);
      if (got.rtr !== want.rtr)
        report_mismatch("frame_rtr", got.rtr, want.rtr);
      if (got.len !== want.len)
        report_mismatch("frame_length", got.len, want.len);
      if (got.data !== want.data)
        report_mismatch("frame_data", got.data, want.data);
      if (got.err !== want.err)
        report_mismatch("fault_code", got.err, want.err);
      if (got.ovf !== want.ovf)
        report_mismatch("overflow_flag", got.ovf, want.ovf);
      if (got.late !== want.late)
        report_mismatch("pdo_late_flag", got.late, want.late);
      if (got.pend !== want.pend)
        report_mismatch("pending_count", got.pend, want.pend);
      if (got.last !== want.last)
        report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic        clk;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  mode           = MODE_SETUP;
  logic [5:0]  buf_index      = '0;
  logic [10:0] ident          = '0;
  logic        rtr            = 1'b0;
  logic [3:0]  length         = '0;
  logic        sync           = 1'b0;
  logic [63:0] payload        = '0;
  logic [1:0]  mailboxes_free = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        frame_valid;
  logic [5:0]  frame_buffer;
  logic [10:0] frame_ident;
  logic        frame_rtr;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;
  logic [1:0]  fault_code;
  logic        overflow_flag;
  logic        pdo_late_flag;
  logic [6:0]  pending_count;
  logic        last;

  tx_frame_board board = new();

  bit          ready_buf[NBUF];
  int          burst_left = 0;
  bit          hold_for_drain = 1'b0;
  int unsigned stall_cycle = 0;

  can_tx_buffer_queue uut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check on accept, then pick the next stall from a rotating pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        board.check_result(txres_t'({frame_valid, frame_buffer, frame_ident, frame_rtr,
                                     frame_length, frame_data, fault_code, overflow_flag,
                                     pdo_late_flag, pending_count, last}));
      stall_cycle++;
      case (stall_cycle[8:7])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_cycle[2:0] < 3'd3);
      endcase
    end
  end

  task automatic issue(input txreq_t r);
    int gap;
    in_valid       <= 1'b1;
    mode           <= r.op;
    buf_index      <= r.idx;
    ident          <= r.ident;
    rtr            <= r.rtr;
    length         <= r.len;
    sync           <= r.sync;
    payload        <= r.payload;
    mailboxes_free <= r.mb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
    if (r.op == MODE_SETUP && r.idx < NBUF) ready_buf[r.idx] = 1'b1;
    if (hold_for_drain) begin
      in_valid <= 1'b0;
      hold_for_drain = 1'b0;
      while (board.awaited_q.size() != 0) @(posedge clk);
    end else if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  function automatic txreq_t noise_req(mode_t op);
    txreq_t r;
    r.op      = op;
    r.idx     = 6'($urandom);
    r.ident   = 11'($urandom);
    r.rtr     = 1'($urandom);
    r.len     = 4'($urandom);
    r.sync    = 1'($urandom);
    r.payload = {$urandom, $urandom};
    r.mb      = 2'($urandom);
    return r;
  endfunction

  task automatic setup_buf(int idx, logic [10:0] id, logic rr, logic [3:0] len, logic sy);
    txreq_t r;
    r       = noise_req(MODE_SETUP);
    r.idx   = 6'(idx);
    r.ident = id;
    r.rtr   = rr;
    r.len   = len;
    r.sync  = sy;
    issue(r);
  endtask

  task automatic send_buf(int idx, logic [63:0] data, logic [1:0] mb);
    txreq_t r;
    r         = noise_req(MODE_SEND);
    r.idx     = 6'(idx);
    r.payload = data;
    r.mb      = mb;
    issue(r);
  endtask

  task automatic free_mb(logic [1:0] mb);
    txreq_t r;
    r    = noise_req(MODE_FREED);
    r.mb = mb;
    issue(r);
  endtask

  task automatic clear_sync();
    issue(noise_req(MODE_CLEAR));
  endtask

  initial begin
    int pick;
    int idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    clear_sync();                           // nothing to drop, late stays low
    setup_buf(0, 11'h7FF, 1'b1, 4'hF, 1'b0);  // length saturates
    setup_buf(31, 11'h000, 1'b0, 4'h0, 1'b1);
    setup_buf(5, 11'($urandom), 1'b0, 4'h8, 1'b1);
    setup_buf(32, 11'($urandom), 1'b1, 4'h3, 1'b0);
    setup_buf(63, 11'($urandom), 1'b0, 4'h3, 1'b1);
    send_buf(63, {$urandom, $urandom}, 2'd1);
    send_buf(0, '1, 2'd3);
    send_buf(5, {$urandom, $urandom}, 2'd0);
    send_buf(5, {$urandom, $urandom}, 2'd0);  // overflow before any freed event
    send_buf(31, '1, 2'd0);
    send_buf(0, {$urandom, $urandom}, 2'd0);
    setup_buf(0, 11'h2A5, 1'b0, 4'h3, 1'b0);  // setup drops a pending buffer
    send_buf(0, {$urandom, $urandom}, 2'd0);
    free_mb(2'd1);
    send_buf(5, {$urandom, $urandom}, 2'd2);  // overflow with a mailbox free
    clear_sync();
    setup_buf(1, 11'($urandom), 1'b1, 4'h1, 1'b0);
    setup_buf(2, 11'($urandom), 1'b0, 4'h7, 1'b0);
    setup_buf(3, 11'($urandom), 1'b0, 4'hC, 1'b1);
    for (int b = 0; b < 4; b++) send_buf(b, {$urandom, $urandom}, 2'd0);
    free_mb(2'd3);
    free_mb(2'd0);
    free_mb(2'd2);

    for (int i = 0; i < 230; i++) begin
      pick = $urandom_range(0, 99);
      if (i == 115 || i == 229) hold_for_drain = 1'b1;
      if (pick < 18) begin
        pick = $urandom_range(0, 99);
        idx = (pick < 80) ? $urandom_range(0, 11) :
              (pick < 92) ? $urandom_range(12, NBUF - 1) : $urandom_range(NBUF, 63);
        setup_buf(idx, 11'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
      end else if (pick < 60) begin
        // only buffers that were set up may be sent
        do begin
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NBUF - 1)
                                              : $urandom_range(0, 7);
        end while (!ready_buf[idx]);
        send_buf(idx, {$urandom, $urandom},
                 ($urandom_range(0, 1) == 0) ? 2'd0 : 2'($urandom_range(1, 3)));
      end else if (pick < 64) begin
        send_buf($urandom_range(NBUF, 63), {$urandom, $urandom}, 2'($urandom));
      end else if (pick < 86) begin
        free_mb(($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3)));
      end else begin
        clear_sync();
      end
    end

    repeat (60) @(posedge clk);
    if (board.awaited_q.size() != 0)
      board.report_mismatch("results never delivered", board.awaited_q.size(), 0);
    $display("requests: %0d setup, %0d send, %0d freed, %0d sync clear",
             board.req_count[MODE_SETUP], board.req_count[MODE_SEND],
             board.req_count[MODE_FREED], board.req_count[MODE_CLEAR]);
    $display("%0d results checked, %0d frames sent, overflow seen %0d, pdo late seen %0d",
             board.results, board.frames, board.ovf_seen, board.late_seen);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", board.awaited_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- can_tx_buffer_queue.f -----
design/cantxq_pkg.sv
design/cantxq_ram.sv
design/cantxq_ctrl.sv
design/cantxq_dp.sv
design/can_tx_buffer_queue.sv
tb/sv/testbench.sv
